/* rtl/x86rda_pkg.sv */
// ----------------------------------------------------------------------------
// x86rda_pkg
// Shared constants and types for the register-direct x86 ALU stage.
// ----------------------------------------------------------------------------
package x86rda_pkg;

  localparam int DataW = 32;
  localparam int RegN  = 8;
  localparam int AddrW = $clog2(RegN);

  localparam logic [1:0] ModDirect = 2'b11;

  localparam logic [7:0] OP_ADD  = 8'h01;
  localparam logic [7:0] OP_SUB  = 8'h29;
  localparam logic [7:0] OP_AND  = 8'h21;
  localparam logic [7:0] OP_OR   = 8'h09;
  localparam logic [7:0] OP_XOR  = 8'h31;
  localparam logic [7:0] OP_NOT  = 8'hf7;
  localparam logic [7:0] OP_CMP  = 8'h39;
  localparam logic [7:0] OP_MOV  = 8'h89;
  localparam logic [7:0] OP_XCHG = 8'h87;

  typedef struct packed {
    logic sign;
    logic zero;
    logic ovf;
  } flags_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    flags_t           flags;
    logic             fault;
    logic             wr_dst;
    logic             wr_src;
  } exec_res_t;

endpackage

/* rtl/x86rda_exec.sv */
// ----------------------------------------------------------------------------
// x86rda_exec
// Decode and execute one register-direct instruction or preset load on
// resolved operands; gives the result, new flags and register write enables.
// ----------------------------------------------------------------------------
module x86rda_exec (
  input  logic                        load_request,
  input  logic [7:0]                  opcode,
  input  logic [7:0]                  modrm,
  input  logic [x86rda_pkg::DataW-1:0] preset_value,
  input  logic [x86rda_pkg::DataW-1:0] a,
  input  logic [x86rda_pkg::DataW-1:0] b,
  input  x86rda_pkg::flags_t          flags_in,
  output x86rda_pkg::exec_res_t       res
);

  logic [x86rda_pkg::DataW-1:0] sum;
  logic [x86rda_pkg::DataW-1:0] diff;
  logic                         ovf_add;
  logic                         ovf_sub;

  localparam int Msb = x86rda_pkg::DataW - 1;

  assign sum     = a + b;
  assign diff    = a - b;
  assign ovf_add = ~(a[Msb] ^ b[Msb]) & (a[Msb] ^ sum[Msb]);
  assign ovf_sub = (a[Msb] ^ b[Msb]) & (a[Msb] ^ diff[Msb]);

  always_comb begin
    res        = '0;
    res.flags  = flags_in;
    if (load_request) begin
      res.value  = preset_value;
      res.wr_dst = 1'b1;
    end else if (modrm[7:6] != x86rda_pkg::ModDirect) begin
      res.fault = 1'b1;
    end else begin
      case (opcode)
        x86rda_pkg::OP_ADD: begin
          res.value  = sum;
          res.flags  = '{sign: sum[Msb], zero: (sum == '0), ovf: ovf_add};
          res.wr_dst = 1'b1;
        end
        x86rda_pkg::OP_SUB: begin
          res.value  = diff;
          res.flags  = '{sign: diff[Msb], zero: (diff == '0), ovf: ovf_sub};
          res.wr_dst = 1'b1;
        end
        x86rda_pkg::OP_CMP: begin
          res.value = diff;
          res.flags = '{sign: diff[Msb], zero: (diff == '0), ovf: ovf_sub};
        end
        x86rda_pkg::OP_AND: begin
          res.value  = a & b;
          res.flags  = '{sign: res.value[Msb], zero: (res.value == '0), ovf: 1'b0};
          res.wr_dst = 1'b1;
        end
        x86rda_pkg::OP_OR: begin
          res.value  = a | b;
          res.flags  = '{sign: res.value[Msb], zero: (res.value == '0), ovf: 1'b0};
          res.wr_dst = 1'b1;
        end
        x86rda_pkg::OP_XOR: begin
          res.value  = a ^ b;
          res.flags  = '{sign: res.value[Msb], zero: (res.value == '0), ovf: 1'b0};
          res.wr_dst = 1'b1;
        end
        x86rda_pkg::OP_NOT: begin
          res.value  = ~a;
          res.flags  = '{sign: res.value[Msb], zero: (res.value == '0), ovf: 1'b0};
          res.wr_dst = 1'b1;
        end
        x86rda_pkg::OP_MOV: begin
          res.value  = b;
          res.wr_dst = 1'b1;
        end
        x86rda_pkg::OP_XCHG: begin
          res.value  = b;
          res.wr_dst = 1'b1;
          res.wr_src = 1'b1;
        end
        default: begin
          res.fault = 1'b1;
        end
      endcase
    end
  end

endmodule

/* rtl/x86_register_direct_alu_top.sv */
// ----------------------------------------------------------------------------
// x86_register_direct_alu_top
// Register-direct x86 ALU stage: eight 32-bit registers in a synchronous
// memory, sign/zero/overflow flags, one instruction or preset load per word.
//
//   channel  dir  payload                                     handshake
//   s_*      in   tuser: load_request                         tvalid/tready
//                 tdata: opcode, modrm, preset_value
//   m_*      out  tuser: fault                                tvalid/tready
//                 tdata: dest_value, sign, zero, overflow
//
// one word per cycle while the output accepts; xchg holds off the next input
// word, since its second register write uses the single memory write port in
// the following cycle; an accepted word goes through a memory read, then
// execute and write back into the output register
// reset clears the register file through per-entry valid bits, at once
// a stalled output holds the execute stage, so the input takes at most one
// more word until the output register is accepted
// ----------------------------------------------------------------------------
module x86_register_direct_alu_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // opcode, modrm, preset_value
  input  logic [0:0]  s_tuser,  // load_request
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // dest_value, sign_flag, zero_flag, overflow_flag
  output logic [0:0]  m_tuser   // fault
);

  localparam int DataW = x86rda_pkg::DataW;
  localparam int AddrW = x86rda_pkg::AddrW;
  localparam int RegN  = x86rda_pkg::RegN;

  logic [DataW-1:0] mem [RegN];
  logic [RegN-1:0]  vld;
  logic [DataW-1:0] rd_a;
  logic [DataW-1:0] rd_b;

  logic             s_fire;
  logic             s1_valid;
  logic             s1_ready;
  logic             s1_fire;
  logic             s1_load;
  logic [7:0]       s1_opcode;
  logic [7:0]       s1_modrm;
  logic [DataW-1:0] s1_preset;
  logic             s1_va;
  logic             s1_vb;
  logic             s1_fw_valid;
  logic [AddrW-1:0] s1_fw_addr;
  logic [DataW-1:0] s1_fw_data;
  logic [AddrW-1:0] s1_dst;
  logic [AddrW-1:0] s1_src;
  logic [DataW-1:0] a_eff;
  logic [DataW-1:0] b_eff;

  logic             xp_valid;
  logic [AddrW-1:0] xp_addr;
  logic [DataW-1:0] xp_data;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;

  x86rda_pkg::flags_t    flags;
  x86rda_pkg::exec_res_t res;

  logic [DataW-1:0] out_value;
  x86rda_pkg::flags_t out_flags;
  logic             out_fault;

  logic [AddrW-1:0] in_dst;
  logic [AddrW-1:0] in_src;

  assign in_dst = s_tdata[8 +: AddrW];
  assign in_src = s_tdata[11 +: AddrW];
  assign s1_dst = s1_modrm[AddrW-1:0];
  assign s1_src = s1_modrm[3 +: AddrW];

  assign s1_ready = !m_tvalid || m_tready;
  assign s1_fire  = s1_valid && s1_ready;
  assign s_tready = !s1_valid || (s1_ready && !res.wr_src);
  assign s_fire   = s_tvalid && s_tready;

  // write port: execute stage first, xchg second write uses the next cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_dst;
    mem_wdata = res.value;
    if (s1_fire && res.wr_dst) begin
      mem_we = 1'b1;
    end else if (xp_valid) begin
      mem_we    = 1'b1;
      mem_waddr = xp_addr;
      mem_wdata = xp_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (s_fire) begin
      rd_a <= mem[in_dst];
      rd_b <= mem[in_src];
    end
  end

  // forward the write that lands on the same edge as the read
  assign a_eff = (s1_fw_valid && s1_fw_addr == s1_dst) ? s1_fw_data :
                 (s1_va ? rd_a : '0);
  assign b_eff = (s1_fw_valid && s1_fw_addr == s1_src) ? s1_fw_data :
                 (s1_vb ? rd_b : '0);

  x86rda_exec u_exec (
    .load_request (s1_load),
    .opcode       (s1_opcode),
    .modrm        (s1_modrm),
    .preset_value (s1_preset),
    .a            (a_eff),
    .b            (b_eff),
    .flags_in     (flags),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_load    <= s_tuser[0];
      s1_opcode  <= s_tdata[7:0];
      s1_modrm   <= s_tdata[15:8];
      s1_preset  <= s_tdata[47:16];
      s1_fw_addr <= mem_waddr;
      s1_fw_data <= mem_wdata;
    end
    if (s1_fire) begin
      out_value <= res.value;
      out_flags <= res.flags;
      out_fault <= res.fault;
      xp_addr   <= s1_src;
      xp_data   <= a_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld         <= '0;
      s1_valid    <= 1'b0;
      s1_va       <= 1'b0;
      s1_vb       <= 1'b0;
      s1_fw_valid <= 1'b0;
      xp_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
      flags       <= '0;
    end else begin
      if (mem_we) begin
        vld[mem_waddr] <= 1'b1;
      end
      if (s_fire) begin
        s1_valid    <= 1'b1;
        s1_va       <= vld[in_dst];
        s1_vb       <= vld[in_src];
        s1_fw_valid <= mem_we;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      xp_valid <= s1_fire && res.wr_src;
      if (s1_fire) begin
        m_tvalid <= 1'b1;
        flags    <= res.flags;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {5'b0, out_flags.ovf, out_flags.zero, out_flags.sign, out_value};
  assign m_tuser = out_fault;

  a_xchg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res.wr_src) |-> !s_tready)
    else $error("input accepted while xchg holds the write port");

  a_second_write_alone: assert property (@(posedge clk) disable iff (rst)
    xp_valid |-> !s1_valid)
    else $error("second xchg write overlaps a live execute stage");

  a_fault_zero_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == '0))
    else $error("faulting result carries a nonzero value");

  a_fault_keeps_flags: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res.fault) |=> (flags == $past(flags)))
    else $error("fault changed the flags");

  a_fault_no_write: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res.fault) |-> !(res.wr_dst || res.wr_src))
    else $error("fault enabled a register write");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for x86_register_direct_alu_top
// Drives preset loads and register-direct instructions into the ALU stage,
// predicts each result word against its own copy of the register file and
// flags, and compares every returned word field by field. Directed tests
// cover operand extremes, every opcode, flag cases and faults; a random run
// follows, with bursty input, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [31:0] value;
    logic        sign;
    logic        zero;
    logic        ovf;
    logic        fault;
  } retire_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // opcode, modrm, preset_value
  logic [0:0]  s_tuser = '0;  // load_request
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // dest_value, sign_flag, zero_flag, overflow_flag
  logic [0:0]  m_tuser;       // fault

  x86_register_direct_alu_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted architectural state
  logic [31:0] gpr [x86rda_pkg::RegN];
  logic        sf, zf, of;
  retire_t     predicted_retires [$];

  int fail_cnt = 0;
  int checked_cnt = 0;
  int load_cnt = 0;
  int instr_cnt = 0;
  int fault_cnt = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int hold_order = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int stall_mode = 0;

  function automatic void set_arith(logic [31:0] a, logic [31:0] b, logic [31:0] r,
                                    logic is_sub);
    sf = r[31];
    zf = (r == 32'd0);
    if (is_sub)
      of = (a[31] ^ b[31]) & (a[31] ^ r[31]);
    else
      of = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
  endfunction

  function automatic void set_logic(logic [31:0] r);
    sf = r[31];
    zf = (r == 32'd0);
    of = 1'b0;
  endfunction

  function automatic retire_t retire_instr(logic ld, logic [7:0] op, logic [7:0] mrm,
                                           logic [31:0] pv);
    logic [2:0]  src;
    logic [2:0]  dst;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    retire_t     res;
    dst = mrm[2:0];
    src = mrm[5:3];
    a = gpr[dst];
    b = gpr[src];
    r = 32'd0;
    res = '0;
    if (ld) begin
      gpr[dst] = pv;
      r = pv;
    end else if (mrm[7:6] != x86rda_pkg::ModDirect) begin
      res.fault = 1'b1;
    end else begin
      case (op)
        x86rda_pkg::OP_ADD: begin
          r = a + b;
          set_arith(a, b, r, 1'b0);
          gpr[dst] = r;
        end
        x86rda_pkg::OP_SUB: begin
          r = a - b;
          set_arith(a, b, r, 1'b1);
          gpr[dst] = r;
        end
        x86rda_pkg::OP_CMP: begin
          r = a - b;
          set_arith(a, b, r, 1'b1);
        end
        x86rda_pkg::OP_AND: begin
          r = a & b;
          set_logic(r);
          gpr[dst] = r;
        end
        x86rda_pkg::OP_OR: begin
          r = a | b;
          set_logic(r);
          gpr[dst] = r;
        end
        x86rda_pkg::OP_XOR: begin
          r = a ^ b;
          set_logic(r);
          gpr[dst] = r;
        end
        x86rda_pkg::OP_NOT: begin
          r = ~a;
          set_logic(r);
          gpr[dst] = r;
        end
        x86rda_pkg::OP_MOV: begin
          r = b;
          gpr[dst] = r;
        end
        x86rda_pkg::OP_XCHG: begin
          gpr[dst] = b;
          gpr[src] = a;
          r = gpr[dst];
        end
        default: res.fault = 1'b1;
      endcase
    end
    res.value = res.fault ? 32'd0 : r;
    res.sign = sf;
    res.zero = zf;
    res.ovf = of;
    return res;
  endfunction

  // one word into the stage, with bursty idling ahead of it
  task automatic send_word(logic ld, logic [7:0] op, logic [7:0] mrm, logic [31:0] pv);
    retire_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {pv, mrm, op};
    s_tuser <= ld;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = retire_instr(ld, op, mrm, pv);
    predicted_retires.push_back(res);
    if (ld)
      load_cnt++;
    else
      instr_cnt++;
    if (res.fault)
      fault_cnt++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (predicted_retires.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_op(int idx);
    case (idx)
      0: return x86rda_pkg::OP_ADD;
      1: return x86rda_pkg::OP_SUB;
      2: return x86rda_pkg::OP_AND;
      3: return x86rda_pkg::OP_OR;
      4: return x86rda_pkg::OP_XOR;
      5: return x86rda_pkg::OP_NOT;
      6: return x86rda_pkg::OP_CMP;
      7: return x86rda_pkg::OP_MOV;
      default: return x86rda_pkg::OP_XCHG;
    endcase
  endfunction

  function automatic logic [31:0] pick_value;
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // output side: stall pattern plus an on-request long hold-off
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt[7:0] == 8'd0)
      stall_mode <= $urandom_range(0, 3);
    if (hold_order != hold_taken) begin
      hold_taken <= hold_order;
      hold_left <= HoldCycles;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= (cycle_cnt % 5 != 0) && (cycle_cnt % 7 != 3);
        default: m_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("x86_register_direct_alu_top verification failed");
      $finish;
    end
  end

  retire_t want;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      checked_cnt <= checked_cnt + 1;
      if (predicted_retires.size() == 0) begin
        $error("unexpected word: tdata %h tuser %h", m_tdata, m_tuser);
        fail_cnt++;
      end else begin
        want = predicted_retires.pop_front();
        if (m_tdata[31:0] !== want.value) begin
          $error("dest_value: expected %h, got %h", want.value, m_tdata[31:0]);
          fail_cnt++;
        end
        if (m_tdata[32] !== want.sign) begin
          $error("sign_flag: expected %b, got %b", want.sign, m_tdata[32]);
          fail_cnt++;
        end
        if (m_tdata[33] !== want.zero) begin
          $error("zero_flag: expected %b, got %b", want.zero, m_tdata[33]);
          fail_cnt++;
        end
        if (m_tdata[34] !== want.ovf) begin
          $error("overflow_flag: expected %b, got %b", want.ovf, m_tdata[34]);
          fail_cnt++;
        end
        if (m_tuser[0] !== want.fault) begin
          $error("fault: expected %b, got %b", want.fault, m_tuser[0]);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_reset_state;
    send_word(1'b0, x86rda_pkg::OP_OR, 8'hc0, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_ADD, 8'hff, 32'h0);
  endtask

  task automatic test_loads;
    send_word(1'b1, 8'hff, 8'h00, 32'h7fff_ffff);
    send_word(1'b1, 8'h00, 8'h01, 32'h0000_0001);
    send_word(1'b1, x86rda_pkg::OP_ADD, 8'h42, 32'h8000_0000);
    send_word(1'b1, 8'h5a, 8'hbb, 32'h0000_0001);
    send_word(1'b1, 8'hc3, 8'hc4, 32'hffff_ffff);
    send_word(1'b1, 8'h3c, 8'h75, 32'ha5a5_a5a5);
    send_word(1'b1, 8'h00, 8'hf6, 32'hffff_ffff);
    send_word(1'b1, 8'hff, 8'h07, 32'h0000_0000);
  endtask

  task automatic test_arith;
    send_word(1'b0, x86rda_pkg::OP_ADD, 8'hc8, 32'h0);  // r0 += r1, positive overflow
    send_word(1'b0, x86rda_pkg::OP_SUB, 8'hda, 32'h0);  // r2 -= r3, negative overflow
    send_word(1'b0, x86rda_pkg::OP_CMP, 8'hda, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_CMP, 8'hdb, 32'h0);  // equal operands
    send_word(1'b0, x86rda_pkg::OP_ADD, 8'hfe, 32'h0);  // r6 += r7, negative result without overflow
  endtask

  task automatic test_logic;
    send_word(1'b0, x86rda_pkg::OP_AND, 8'hec, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_OR, 8'hec, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_XOR, 8'he4, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_NOT, 8'hfc, 32'h0);  // reg bits ignored
    send_word(1'b0, x86rda_pkg::OP_NOT, 8'hc7, 32'h0);
  endtask

  task automatic test_moves;
    send_word(1'b0, x86rda_pkg::OP_MOV, 8'hc8, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_XCHG, 8'hda, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_XCHG, 8'hd2, 32'h0);  // same register
    send_word(1'b0, x86rda_pkg::OP_XCHG, 8'hf9, 32'h0);
  endtask

  task automatic test_faults;
    send_word(1'b0, x86rda_pkg::OP_ADD, 8'h08, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_XCHG, 8'h48, 32'h0);
    send_word(1'b0, x86rda_pkg::OP_NOT, 8'h88, 32'h0);
    send_word(1'b0, 8'h00, 8'hc0, 32'h0);
    send_word(1'b0, 8'hff, 8'hc9, 32'h0);
    drain();
  endtask

  task automatic random_word;
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 15)
      send_word(1'b1, 8'($urandom), 8'($urandom), pick_value());
    else if (kind < 90)
      send_word(1'b0, pick_op($urandom_range(0, 8)), {2'b11, 6'($urandom)}, $urandom);
    else if (kind < 95)
      send_word(1'b0, pick_op($urandom_range(0, 8)), {2'($urandom_range(0, 2)),
                6'($urandom)}, $urandom);
    else
      send_word(1'b0, 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic test_backpressure;
    hold_order++;
    @(posedge clk);
    @(posedge clk);
    repeat (40) random_word();
    drain();
  endtask

  task automatic test_random;
    repeat (1700) begin
      random_word();
      if ($urandom_range(0, 499) == 0)
        drain();
    end
  endtask

  initial begin
    for (int i = 0; i < x86rda_pkg::RegN; i++) gpr[i] = 32'd0;
    sf = 1'b0;
    zf = 1'b0;
    of = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_loads();
    test_arith();
    test_logic();
    test_moves();
    test_faults();
    test_backpressure();
    test_random();
    s_tvalid <= 1'b0;
    while (predicted_retires.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d preset loads and %0d instructions, %0d of them faulting",
             load_cnt, instr_cnt, fault_cnt);
    $display("%0d result words compared in %0d cycles", checked_cnt, cycle_cnt);
    if (fail_cnt == 0 && predicted_retires.size() == 0) begin
      $display("x86_register_direct_alu_top verification clean");
    end else begin
      $display("x86_register_direct_alu_top verification failed");
    end
    $finish;
  end

endmodule
